[rtl/core/qpic_pkg.sv]
// qpic_pkg: shared types, field layout and codes for the QPACK prefix codec.
// No dependencies; imported by every module under rtl/core.

package qpic_pkg;

    // Fixed field widths of the stream words and the capacity register
    localparam int FIELD_W   = 32;
    localparam int CAP_W     = 32;
    localparam int STATUS_W  = 2;
    localparam int CAP_SHIFT = 5;                    // max entries = capacity / 32
    localparam int ME_W      = CAP_W - CAP_SHIFT;    // max entries width
    localparam int FR_W      = ME_W + 1;             // full range = 2 * max entries

    // Input word layout, lowest bit first
    localparam int IN_RIC_LSB   = 0;
    localparam int IN_BASE_LSB  = IN_RIC_LSB + FIELD_W;
    localparam int IN_TNI_LSB   = IN_BASE_LSB + FIELD_W;
    localparam int IN_EIC_LSB   = IN_TNI_LSB + FIELD_W;
    localparam int IN_SIGN_BIT  = IN_EIC_LSB + FIELD_W;
    localparam int IN_DELTA_LSB = IN_SIGN_BIT + 1;
    localparam int IN_USED_W    = IN_DELTA_LSB + FIELD_W;
    localparam int S_DATA_W     = ((IN_USED_W + 7) / 8) * 8;

    // Output word layout, lowest bit first
    localparam int OUT_ENC_LSB    = 0;
    localparam int OUT_SIGN_BIT   = OUT_ENC_LSB + FIELD_W;
    localparam int OUT_DELTA_LSB  = OUT_SIGN_BIT + 1;
    localparam int OUT_REQ_LSB    = OUT_DELTA_LSB + FIELD_W;
    localparam int OUT_BASE_LSB   = OUT_REQ_LSB + FIELD_W;
    localparam int OUT_STATUS_LSB = OUT_BASE_LSB + FIELD_W;
    localparam int OUT_USED_W     = OUT_STATUS_LSB + STATUS_W;
    localparam int M_DATA_W       = ((OUT_USED_W + 7) / 8) * 8;

    // Operation kind carried in tuser
    localparam logic KIND_ENCODE = 1'b0;
    localparam logic KIND_DECODE = 1'b1;

    typedef logic [STATUS_W-1:0] status_t;
    localparam status_t ST_OK      = 2'd0;
    localparam status_t ST_INVALID = 2'd1;
    localparam status_t ST_RANGE   = 2'd2;

    // How a word is handled, settled before the divider chain
    typedef logic [2:0] cls_t;
    localparam cls_t CLS_ZERO = 3'd0;   // all-zero result
    localparam cls_t CLS_NOME = 3'd1;   // capacity below one entry
    localparam cls_t CLS_BAD  = 3'd2;   // encoded count above full range
    localparam cls_t CLS_ENC  = 3'd3;
    localparam cls_t CLS_DEC  = 3'd4;

    typedef struct packed {
        cls_t cls;
        logic ric_zero;     // encode: required count is zero
        logic sign_in;      // decode: sign from the prefix
        logic sign_out;     // encode: base below required count
    } flags_t;

endpackage

[rtl/core/qpic_div_cell.sv]
// qpic_div_cell: one restoring-division step of the remainder chain.
// Depends on qpic_pkg (field widths).

module qpic_div_cell #(
    parameter int MW = 33,
    parameter int SW = 104
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      en,
    input  logic [qpic_pkg::FR_W-1:0] fr,
    input  logic                      in_valid,
    input  logic [qpic_pkg::FR_W-1:0] in_rem,
    input  logic [MW-1:0]             in_div,
    input  logic [SW-1:0]             in_side,
    output logic                      out_valid,
    output logic [qpic_pkg::FR_W-1:0] out_rem,
    output logic [MW-1:0]             out_div,
    output logic [SW-1:0]             out_side
);
    import qpic_pkg::*;

    logic              valid_reg;
    logic [FR_W-1:0]   rem_reg, rem_next;
    logic [MW-1:0]     div_reg;
    logic [SW-1:0]     side_reg;
    logic [FR_W:0]     shifted;
    logic [FR_W:0]     diff;

    // bring in the next dividend bit, subtract the divisor when it fits
    assign shifted  = {in_rem, in_div[MW-1]};
    assign diff     = shifted - {1'b0, fr};
    assign rem_next = (shifted >= {1'b0, fr}) ? diff[FR_W-1:0] : shifted[FR_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg  <= rem_next;
            div_reg  <= {in_div[MW-2:0], 1'b0};
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_div   = div_reg;
    assign out_side  = side_reg;

endmodule

[rtl/core/qpic_resolve.sv]
// qpic_resolve: turns the remainder into the decoded count and base, or the
// encoded count. Two register stages, then the result fields. Uses qpic_pkg.

module qpic_resolve #(
    parameter int CW = 32,
    parameter int MW = 33
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  logic [qpic_pkg::FR_W-1:0]    fr,
    input  logic                         in_valid,
    input  logic [qpic_pkg::FR_W-1:0]    in_rem,
    input  qpic_pkg::flags_t             in_flags,
    input  logic [MW-1:0]                in_wide,    // max value (decode) or delta base (encode)
    input  logic [CW-1:0]                in_em1,     // encoded count minus one
    input  logic [CW-1:0]                in_delta,
    output logic                         out_valid,
    output logic [qpic_pkg::FIELD_W-1:0] encoded_count,
    output logic                         sign,
    output logic [qpic_pkg::FIELD_W-1:0] delta_base,
    output logic [qpic_pkg::FIELD_W-1:0] required_count,
    output logic [qpic_pkg::FIELD_W-1:0] base,
    output qpic_pkg::status_t            status
);
    import qpic_pkg::*;

    // stage A: floor(max / range) * range, wrapped back when the count is ahead
    logic            a_valid_reg;
    flags_t          a_flags_reg;
    logic [MW-1:0]   a_q_reg;
    logic            a_bad_reg;
    logic [CW-1:0]   a_em1_reg;
    logic [CW-1:0]   a_delta_reg;
    logic [FR_W:0]   a_enc_reg;
    logic [CW-1:0]   a_dbo_reg;

    logic [MW-1:0]   q_full;
    logic [MW-1:0]   q_wrap;
    logic            ahead;

    assign q_full = in_wide - MW'(in_rem);
    assign q_wrap = in_wide - MW'(in_rem) - MW'(fr);
    assign ahead  = MW'(in_em1) > MW'(in_rem);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_flags_reg <= in_flags;
            a_q_reg     <= ahead ? q_wrap : q_full;
            // wrapping below the first range is not a valid encoding
            a_bad_reg   <= ahead && (in_wide == MW'(in_rem));
            a_em1_reg   <= in_em1;
            a_delta_reg <= in_delta;
            a_enc_reg   <= in_flags.ric_zero ? '0 : ({1'b0, in_rem} + 1'b1);
            a_dbo_reg   <= in_wide[CW-1:0];
        end
    end

    // stage B: required count and its checks
    logic            b_valid_reg;
    flags_t          b_flags_reg;
    logic [CW-1:0]   b_ric_reg;
    status_t         b_st_reg;
    logic [CW-1:0]   b_delta_reg;
    logic [FR_W:0]   b_enc_reg;
    logic [CW-1:0]   b_dbo_reg;

    logic [MW-1:0]   ric;
    status_t         b_st_next;

    assign ric = a_q_reg + MW'(a_em1_reg);

    always_comb begin
        priority if (a_bad_reg || ric == '0) begin
            b_st_next = ST_INVALID;
        end else if (|ric[MW-1:CW]) begin
            b_st_next = ST_RANGE;
        end else begin
            b_st_next = ST_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (en) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b_flags_reg <= a_flags_reg;
            b_ric_reg   <= ric[CW-1:0];
            b_st_reg    <= b_st_next;
            b_delta_reg <= a_delta_reg;
            b_enc_reg   <= a_enc_reg;
            b_dbo_reg   <= a_dbo_reg;
        end
    end

    // result: base from the delta, then select by class
    logic [CW:0]     base_sum;
    logic [CW-1:0]   base_dif;
    logic [CW-1:0]   base_val;
    status_t         dec_st;

    assign base_sum = {1'b0, b_delta_reg} + {1'b0, b_ric_reg};
    assign base_dif = b_ric_reg - b_delta_reg - 1'b1;

    always_comb begin
        dec_st   = b_st_reg;
        base_val = '0;
        if (b_st_reg == ST_OK) begin
            if (!b_flags_reg.sign_in) begin
                if (base_sum[CW]) begin
                    dec_st = ST_RANGE;
                end else begin
                    base_val = base_sum[CW-1:0];
                end
            end else if (b_delta_reg >= b_ric_reg) begin
                dec_st = ST_RANGE;      // base would drop below zero
            end else begin
                base_val = base_dif;
            end
        end
    end

    always_comb begin
        encoded_count  = '0;
        sign           = 1'b0;
        delta_base     = '0;
        required_count = '0;
        base           = '0;
        status         = ST_OK;
        unique case (b_flags_reg.cls)
            CLS_ENC: begin
                encoded_count = FIELD_W'(b_enc_reg);
                sign          = b_flags_reg.sign_out;
                delta_base    = FIELD_W'(b_dbo_reg);
            end
            CLS_NOME: begin
                status = ST_RANGE;
            end
            CLS_BAD: begin
                status = ST_INVALID;
            end
            CLS_DEC: begin
                status = dec_st;
                if (dec_st == ST_OK) begin
                    required_count = FIELD_W'(b_ric_reg);
                    base           = FIELD_W'(base_val);
                end
            end
            default: begin
                status = ST_OK;
            end
        endcase
    end

    assign out_valid = b_valid_reg;

endmodule

[rtl/core/qpack_insert_count_codec_unit.sv]
// qpack_insert_count_codec_unit: QPACK field section prefix encoder/decoder.
// Depends on qpic_pkg, qpic_div_cell and qpic_resolve.
//
//  port group   dir  handshake            contents
//  s_*          in   s_tvalid / s_tready  one request word, kind in s_tuser
//  m_*          out  m_tvalid / m_tready  one result word per request
//  cfg_*        in   cfg_we               table capacity in bytes
//
// One word is taken per cycle while s_tready is high. A request passes through one divider
// cell per dividend bit, the two resolve stages and the output register; MW, the cell count,
// is one more than the wider of COUNT_WIDTH and the 27-bit entry count (33 at the default).
// Reset clears all valid flags and the capacity; data registers keep junk.
// A stalled output parks one word in a skid register; s_tready then drops and
// the whole chain holds until the skid drains.

module qpack_insert_count_codec_unit #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [qpic_pkg::CAP_W-1:0]    cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // required_insert_count, base_index, total_inserts, encoded_insert_count,
    // sign_in, delta_base_in, zero pad
    input  logic [qpic_pkg::S_DATA_W-1:0] s_tdata,
    input  logic                          s_tuser,   // kind
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // encoded_count_out, sign_out, delta_base_out, required_count_out,
    // base_out, status, zero pad
    output logic [qpic_pkg::M_DATA_W-1:0] m_tdata
);
    import qpic_pkg::*;

    localparam int CW = COUNT_WIDTH;
    localparam int MW = ((CW > ME_W) ? CW : ME_W) + 1;
    localparam int FL_W = $bits(flags_t);
    localparam int SW = FL_W + MW + 2 * CW;

    // capacity register and derived range
    logic [CAP_W-1:0] cap_reg;
    logic [ME_W-1:0]  me;
    logic [FR_W-1:0]  fr;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= '0;
        end else if (cfg_we) begin
            cap_reg <= cfg_wdata;
        end
    end

    assign me = ME_W'(cap_reg >> CAP_SHIFT);
    assign fr = {me, 1'b0};

    // chain enable: hold everything while the skid holds a word
    logic en;
    logic sk_valid_reg;

    assign en       = !sk_valid_reg;
    assign s_tready = en;

    // request decode ahead of the chain
    logic [CW-1:0] ric_in, base_in, tni, eic, delta, em1, dbo;
    logic [MW-1:0] maxv, dividend, wide;
    flags_t        flags;

    assign ric_in = CW'(s_tdata[IN_RIC_LSB +: FIELD_W]);
    assign base_in = CW'(s_tdata[IN_BASE_LSB +: FIELD_W]);
    assign tni    = CW'(s_tdata[IN_TNI_LSB +: FIELD_W]);
    assign eic    = CW'(s_tdata[IN_EIC_LSB +: FIELD_W]);
    assign delta  = CW'(s_tdata[IN_DELTA_LSB +: FIELD_W]);
    assign em1    = eic - 1'b1;
    assign maxv   = MW'(tni) + MW'(me);

    always_comb begin
        priority if (cap_reg == '0) begin
            flags.cls = CLS_ZERO;
        end else if (me == '0) begin
            flags.cls = CLS_NOME;
        end else if (s_tuser == KIND_ENCODE) begin
            flags.cls = CLS_ENC;
        end else if (eic == '0) begin
            flags.cls = CLS_ZERO;
        end else if (MW'(eic) > MW'(fr)) begin
            flags.cls = CLS_BAD;
        end else begin
            flags.cls = CLS_DEC;
        end
        flags.ric_zero = (ric_in == '0);
        flags.sign_in  = s_tdata[IN_SIGN_BIT];
        flags.sign_out = (ric_in > base_in);
    end

    assign dbo      = flags.sign_out ? (ric_in - base_in - 1'b1) : (base_in - ric_in);
    assign dividend = (flags.cls == CLS_DEC) ? maxv : MW'(ric_in);
    assign wide     = (flags.cls == CLS_DEC) ? maxv : MW'(dbo);

    // remainder chain, one cell per dividend bit
    logic            c_valid [MW+1];
    logic [FR_W-1:0] c_rem   [MW+1];
    logic [MW-1:0]   c_div   [MW+1];
    logic [SW-1:0]   c_side  [MW+1];

    assign c_valid[0] = s_tvalid;
    assign c_rem[0]   = '0;
    assign c_div[0]   = dividend;
    assign c_side[0]  = {flags, wide, em1, delta};

    for (genvar g = 0; g < MW; g++) begin : g_cell
        qpic_div_cell #(
            .MW (MW),
            .SW (SW)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .fr        (fr),
            .in_valid  (c_valid[g]),
            .in_rem    (c_rem[g]),
            .in_div    (c_div[g]),
            .in_side   (c_side[g]),
            .out_valid (c_valid[g+1]),
            .out_rem   (c_rem[g+1]),
            .out_div   (c_div[g+1]),
            .out_side  (c_side[g+1])
        );
    end

    flags_t        r_flags;
    logic [MW-1:0] r_wide;
    logic [CW-1:0] r_em1, r_delta;

    assign {r_flags, r_wide, r_em1, r_delta} = c_side[MW];

    logic                res_valid;
    logic [FIELD_W-1:0]  res_enc, res_dbo, res_req, res_base;
    logic                res_sign;
    status_t             res_status;

    qpic_resolve #(
        .CW (CW),
        .MW (MW)
    ) u_resolve (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .en             (en),
        .fr             (fr),
        .in_valid       (c_valid[MW]),
        .in_rem         (c_rem[MW]),
        .in_flags       (r_flags),
        .in_wide        (r_wide),
        .in_em1         (r_em1),
        .in_delta       (r_delta),
        .out_valid      (res_valid),
        .encoded_count  (res_enc),
        .sign           (res_sign),
        .delta_base     (res_dbo),
        .required_count (res_req),
        .base           (res_base),
        .status         (res_status)
    );

    // output register with one skid word
    logic [M_DATA_W-1:0] res_word;
    logic [M_DATA_W-1:0] out_data_reg;
    logic [M_DATA_W-1:0] sk_data_reg;
    logic                out_valid_reg;
    logic                take;
    logic                out_free;

    assign res_word = M_DATA_W'({res_status, res_base, res_req, res_dbo, res_sign, res_enc});
    assign take     = en && res_valid;
    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            sk_valid_reg  <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= sk_valid_reg || take;
            sk_valid_reg  <= 1'b0;
        end else if (take) begin
            sk_valid_reg  <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            out_data_reg <= sk_valid_reg ? sk_data_reg : res_word;
        end else if (take) begin
            sk_data_reg <= res_word;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // skid fills only behind a stalled output word
    a_skid_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(sk_valid_reg) |-> $past(out_valid_reg && !m_tready))
        else $error("skid filled while output was free");

    // input side stalls only while a word waits at the output
    a_ready_low: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> out_valid_reg)
        else $error("input stalled with empty output");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[OUT_STATUS_LSB +: STATUS_W] != 2'd3))
        else $error("undefined status code");

    // decoded values appear only with a clean status
    a_dec_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && ((m_tdata[OUT_REQ_LSB +: FIELD_W] != '0)
                     || (m_tdata[OUT_BASE_LSB +: FIELD_W] != '0))
        |-> (m_tdata[OUT_STATUS_LSB +: STATUS_W] == ST_OK))
        else $error("decoded value with error status");

endmodule

[tb/tb_qpack_insert_count_codec_unit.sv]
`timescale 1ns / 100ps
// Self-checking testbench for qpack_insert_count_codec_unit (QPACK prefix encode/decode).
// Needs qpic_pkg and the codec RTL; a directed table runs first, then random traffic
// over several table capacities, each result checked against the in-bench predictor or a typed table row.

module tb_qpack_insert_count_codec_unit;
    import qpic_pkg::*;

    localparam int          PIPE_LAT   = 32 + 4;
    localparam int          STALL_MAX  = 5000;
    localparam logic [31:0] ONES       = 32'hFFFF_FFFF;

    typedef struct packed {
        logic        kind;
        logic [31:0] ric;
        logic [31:0] base;
        logic [31:0] tni;
        logic [31:0] eic;
        logic        sign;
        logic [31:0] delta;
    } prefix_req_t;

    typedef struct packed {
        logic [31:0] enc;
        logic        sign;
        logic [31:0] delta;
        logic [31:0] req;
        logic [31:0] base;
        status_t     status;
    } prefix_res_t;

    typedef struct packed {
        logic [31:0] cap;
        prefix_req_t req;
        logic        typed;
        prefix_res_t want;
    } dir_row_t;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                cfg_we    = 1'b0;
    logic [CAP_W-1:0]    cfg_wdata = '0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata   = '0;
    logic                s_tuser   = 1'b0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    prefix_res_t awaited_prefixes[$];
    dir_row_t    dir_tab[$];
    logic [31:0] cur_cap = '0;
    int          src_idle_pct = 0;
    int          snk_idle_pct = 0;
    int          mismatches = 0;
    int          results_checked = 0;
    int          stall_cycles = 0;
    int          cap_writes = 0;
    int          dir_sent = 0;
    int          rand_sent = 0;
    prefix_res_t want_res, got_res;

    qpack_insert_count_codec_unit #(.COUNT_WIDTH(32)) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Expected prefix fields for one request under a given table capacity
    function automatic prefix_res_t predict_prefix(prefix_req_t r, logic [31:0] cap);
        longint unsigned me, fr, ric_in, base_in, tni, eic, delta, maxv, ric, b;
        status_t         st;
        prefix_res_t     o;
        o       = '0;
        st      = ST_OK;
        me      = cap >> CAP_SHIFT;
        fr      = 2 * me;
        ric_in  = r.ric;
        base_in = r.base;
        tni     = r.tni;
        eic     = r.eic;
        delta   = r.delta;
        b       = 0;
        if (cap == 0) begin
            return o;
        end
        if (me == 0) begin
            o.status = ST_RANGE;
            return o;
        end
        if (r.kind == KIND_ENCODE) begin
            o.enc = (ric_in == 0) ? 32'd0 : 32'((ric_in % fr) + 1);
            if (ric_in > base_in) begin
                o.sign  = 1'b1;
                o.delta = 32'(ric_in - base_in - 1);
            end else begin
                o.sign  = 1'b0;
                o.delta = 32'(base_in - ric_in);
            end
            return o;
        end
        if (eic == 0)
            return o;
        if (eic > fr) begin
            o.status = ST_INVALID;
            return o;
        end
        maxv = tni + me;
        ric  = (maxv / fr) * fr + eic - 1;
        if (ric > maxv) begin
            if (ric <= fr)
                st = ST_INVALID;
            else
                ric = ric - fr;
        end
        if (st == ST_OK && ric == 0)
            st = ST_INVALID;
        if (st == ST_OK && ric > 64'hFFFF_FFFF)
            st = ST_RANGE;
        if (st == ST_OK) begin
            if (r.sign == 1'b0) begin
                b = delta + ric;
                if (b > 64'hFFFF_FFFF)
                    st = ST_RANGE;
            end else if (delta >= ric) begin
                st = ST_RANGE;
            end else begin
                b = ric - delta - 1;
            end
        end
        if (st == ST_OK) begin
            o.req  = 32'(ric);
            o.base = 32'(b);
        end
        o.status = st;
        return o;
    endfunction

    function automatic dir_row_t mk_row(logic [31:0] cap, logic kind, logic [31:0] ric,
                                        logic [31:0] base, logic [31:0] tni,
                                        logic [31:0] eic, logic sign, logic [31:0] delta,
                                        logic typed, logic [31:0] w_enc, logic w_sign,
                                        logic [31:0] w_delta, status_t w_st);
        dir_row_t row;
        row.cap          = cap;
        row.req.kind     = kind;
        row.req.ric      = ric;
        row.req.base     = base;
        row.req.tni      = tni;
        row.req.eic      = eic;
        row.req.sign     = sign;
        row.req.delta    = delta;
        row.typed        = typed;
        row.want.enc     = w_enc;
        row.want.sign    = w_sign;
        row.want.delta   = w_delta;
        row.want.req     = '0;
        row.want.base    = '0;
        row.want.status  = w_st;
        return row;
    endfunction

    // Mix of extremes, small values and full-range noise
    function automatic logic [31:0] pick_count();
        case ($urandom_range(5))
            0:       return $urandom_range(0, 3);
            1:       return ONES - $urandom_range(0, 3);
            2:       return $urandom_range(0, 1000);
            default: return $urandom;
        endcase
    endfunction

    function automatic prefix_req_t make_random_req();
        prefix_req_t r, e;
        prefix_res_t enc_res;
        int unsigned me;
        int          pick;
        me      = cur_cap >> CAP_SHIFT;
        pick    = $urandom_range(99);
        r.kind  = KIND_ENCODE;
        r.ric   = pick_count();
        r.base  = ($urandom_range(2) == 0) ? r.ric + $urandom_range(0, 40) - 20 : pick_count();
        r.tni   = pick_count();
        r.eic   = pick_count();
        r.sign  = $urandom_range(1);
        r.delta = pick_count();
        if (pick < 40 || me == 0)
            return r;
        r.kind = KIND_DECODE;
        if (pick < 85) begin
            // encode a plausible count near the decoder's total, then decode it
            e       = r;
            e.kind  = KIND_ENCODE;
            e.ric   = r.tni + me - $urandom_range(0, 2 * me + 1);
            e.base  = ($urandom_range(3) == 0) ? $urandom : e.ric + $urandom_range(0, 40) - 20;
            enc_res = predict_prefix(e, cur_cap);
            r.eic   = enc_res.enc;
            r.sign  = enc_res.sign;
            r.delta = enc_res.delta;
        end else if ($urandom_range(1) == 1) begin
            r.eic = $urandom_range(0, 2 * me + 2);
        end
        return r;
    endfunction

    task automatic send_word(input prefix_req_t r, input prefix_res_t want);
        logic [S_DATA_W-1:0] word;
        word = '0;
        word[IN_RIC_LSB   +: FIELD_W] = r.ric;
        word[IN_BASE_LSB  +: FIELD_W] = r.base;
        word[IN_TNI_LSB   +: FIELD_W] = r.tni;
        word[IN_EIC_LSB   +: FIELD_W] = r.eic;
        word[IN_SIGN_BIT]             = r.sign;
        word[IN_DELTA_LSB +: FIELD_W] = r.delta;
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tuser  <= r.kind;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        awaited_prefixes.push_back(want);
    endtask

    // Drain the pipe, then write the capacity while the block is idle
    task automatic set_capacity(input logic [31:0] cap);
        s_tvalid <= 1'b0;
        while (awaited_prefixes.size() != 0)
            @(posedge aclk);
        repeat (PIPE_LAT + 4) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= cap;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        cur_cap    = cap;
        cap_writes++;
    endtask

    task automatic check_field(input string name, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (want_v !== got_v) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want_v, got_v);
            mismatches++;
        end
    endtask

    always @(posedge aclk)
        m_tready <= ($urandom_range(99) >= snk_idle_pct);

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (m_tvalid && m_tready) begin
            if (awaited_prefixes.size() == 0) begin
                $display("%0t: result word with nothing expected, actual %h", $time, m_tdata);
                mismatches++;
            end else begin
                want_res        = awaited_prefixes.pop_front();
                got_res.enc     = m_tdata[OUT_ENC_LSB   +: FIELD_W];
                got_res.sign    = m_tdata[OUT_SIGN_BIT];
                got_res.delta   = m_tdata[OUT_DELTA_LSB +: FIELD_W];
                got_res.req     = m_tdata[OUT_REQ_LSB   +: FIELD_W];
                got_res.base    = m_tdata[OUT_BASE_LSB  +: FIELD_W];
                got_res.status  = m_tdata[OUT_STATUS_LSB +: STATUS_W];
                check_field("encoded_count_out",  want_res.enc,    got_res.enc);
                check_field("sign_out",           32'(want_res.sign),  32'(got_res.sign));
                check_field("delta_base_out",     want_res.delta,  got_res.delta);
                check_field("required_count_out", want_res.req,    got_res.req);
                check_field("base_out",           want_res.base,   got_res.base);
                check_field("status",             32'(want_res.status), 32'(got_res.status));
                results_checked++;
            end
        end
    end

    always @(posedge aclk) begin
        if (stall_cycles >= STALL_MAX) begin
            $display("%0t: no word moved for %0d cycles", $time, stall_cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        logic [31:0] phase_cap[8];
        int          phase_len[8];
        prefix_req_t r;

        // capacity 0, below one entry, one entry, four entries, then the largest
        dir_tab.push_back(mk_row(0, KIND_ENCODE, ONES, ONES, ONES, ONES, 1, ONES,
                                 1, 0, 0, 0, ST_OK));
        dir_tab.push_back(mk_row(0, KIND_DECODE, ONES, ONES, ONES, ONES, 1, ONES,
                                 1, 0, 0, 0, ST_OK));
        dir_tab.push_back(mk_row(31, KIND_ENCODE, ONES, 0, 0, 0, 0, 0, 1, 0, 0, 0, ST_RANGE));
        dir_tab.push_back(mk_row(31, KIND_DECODE, 0, 0, ONES, 1, 0, 0, 1, 0, 0, 0, ST_RANGE));
        dir_tab.push_back(mk_row(32, KIND_ENCODE, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, ST_OK));
        dir_tab.push_back(mk_row(32, KIND_ENCODE, 5, 9, 0, 0, 0, 0, 0, 0, 0, 0, ST_OK));
        dir_tab.push_back(mk_row(32, KIND_ENCODE, 9, 5, 0, 0, 0, 0, 0, 0, 0, 0, ST_OK));
        dir_tab.push_back(mk_row(32, KIND_ENCODE, ONES, ONES, 0, 0, 0, 0, 0, 0, 0, 0, ST_OK));
        dir_tab.push_back(mk_row(32, KIND_ENCODE, ONES, 0, 0, 0, 0, 0, 0, 0, 0, 0, ST_OK));
        dir_tab.push_back(mk_row(32, KIND_ENCODE, 0, ONES, 0, 0, 0, 0, 0, 0, 0, 0, ST_OK));
        dir_tab.push_back(mk_row(32, KIND_DECODE, 0, 0, ONES, 0, 1, ONES, 1, 0, 0, 0, ST_OK));
        dir_tab.push_back(mk_row(32, KIND_DECODE, 0, 0, 7, 3, 0, 0, 1, 0, 0, 0, ST_INVALID));
        dir_tab.push_back(mk_row(32, KIND_DECODE, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0, ST_OK));
        dir_tab.push_back(mk_row(32, KIND_DECODE, 0, 0, 10, 2, 0, 3, 0, 0, 0, 0, ST_OK));
        // wrap lands at or below the full range
        dir_tab.push_back(mk_row(128, KIND_DECODE, 0, 0, 0, 6, 0, 0, 0, 0, 0, 0, ST_OK));
        // decoded count past the counter width, then base just fits and just overflows
        dir_tab.push_back(mk_row(128, KIND_DECODE, 0, 0, ONES, 4, 0, 0, 0, 0, 0, 0, ST_OK));
        dir_tab.push_back(mk_row(128, KIND_DECODE, 0, 0, ONES, 5, 0, 3, 0, 0, 0, 0, ST_OK));
        dir_tab.push_back(mk_row(128, KIND_DECODE, 0, 0, ONES, 5, 0, 4, 0, 0, 0, 0, ST_OK));
        // negative base, then base exactly zero
        dir_tab.push_back(mk_row(128, KIND_DECODE, 0, 0, 20, 6, 1, 21, 0, 0, 0, 0, ST_OK));
        dir_tab.push_back(mk_row(128, KIND_DECODE, 0, 0, 20, 6, 1, 20, 0, 0, 0, 0, ST_OK));
        dir_tab.push_back(mk_row(128, KIND_ENCODE, 100, 100, 0, 0, 0, 0, 0, 0, 0, 0, ST_OK));
        dir_tab.push_back(mk_row(ONES, KIND_ENCODE, ONES, ONES, 0, 0, 0, 0, 0, 0, 0, 0, ST_OK));
        dir_tab.push_back(mk_row(ONES, KIND_ENCODE, 1, ONES, 0, 0, 0, 0, 0, 0, 0, 0, ST_OK));
        dir_tab.push_back(mk_row(ONES, KIND_DECODE, 0, 0, ONES, 32'h0FFF_FFFE, 0, 0,
                                 0, 0, 0, 0, ST_OK));
        dir_tab.push_back(mk_row(ONES, KIND_DECODE, 0, 0, 0, 1, 1, 0, 0, 0, 0, 0, ST_OK));

        phase_cap = '{32, 32 * $urandom_range(2, 40), ONES, $urandom, 31,
                      32 * $urandom_range(2, 20) + $urandom_range(0, 31), 0, 32'hFFFF_FFE0};
        phase_len = '{150, 100, 100, 100, 30, 100, 30, 90};

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        src_idle_pct = 6;
        snk_idle_pct = 58;
        foreach (dir_tab[i]) begin
            if (dir_tab[i].cap != cur_cap)
                set_capacity(dir_tab[i].cap);
            send_word(dir_tab[i].req, dir_tab[i].typed ? dir_tab[i].want
                                                      : predict_prefix(dir_tab[i].req, cur_cap));
            dir_sent++;
        end

        for (int ph = 0; ph < 8; ph++) begin
            set_capacity(phase_cap[ph]);
            // sender-light/receiver-heavy, then swapped, then no idling
            if (ph < 3) begin
                src_idle_pct = 6;
                snk_idle_pct = 58;
            end else if (ph < 6) begin
                src_idle_pct = 58;
                snk_idle_pct = 6;
            end else begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            for (int n = 0; n < phase_len[ph]; n++) begin
                r = make_random_req();
                send_word(r, predict_prefix(r, cur_cap));
                rand_sent++;
            end
        end

        s_tvalid <= 1'b0;
        while (awaited_prefixes.size() != 0)
            @(posedge aclk);
        repeat (PIPE_LAT + 8) @(posedge aclk);

        $display("sent %0d table and %0d random prefixes over %0d capacity writes",
                 dir_sent, rand_sent, cap_writes);
        $display("checked %0d result words, %0d field mismatches", results_checked, mismatches);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

[sim.f]
rtl/core/qpic_pkg.sv
rtl/core/qpic_div_cell.sv
rtl/core/qpic_resolve.sv
rtl/core/qpack_insert_count_codec_unit.sv
tb/tb_qpack_insert_count_codec_unit.sv
